// ===== rtl/quoted_field_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// quoted_field_tokenizer_macros
// assertion macros for the tokenizer rtl
// ----------------------------------------------------------------------------
`ifndef QUOTED_FIELD_TOKENIZER_MACROS_SVH
`define QUOTED_FIELD_TOKENIZER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define QFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qft assertion failed");

// next-cycle implication
`define QFT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qft assertion failed");

`else

`define QFT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QFT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/qft_pkg.sv =====
// ----------------------------------------------------------------------------
// qft_pkg
// types and constants of the quote-aware field tokenizer
// ----------------------------------------------------------------------------
package qft_pkg;

    localparam int SEP_REGS = 4;

    // register indexes
    localparam logic [2:0] REG_MAX_TOKENS = 3'd0;
    localparam logic [2:0] REG_SEP_COUNT  = 3'd1;
    localparam logic [2:0] REG_SEP_A      = 3'd2;
    localparam logic [2:0] REG_SEP_B      = 3'd3;
    localparam logic [2:0] REG_SEP_C      = 3'd4;
    localparam logic [2:0] REG_SEP_D      = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // stop causes
    localparam logic [1:0] CAUSE_END     = 2'd0;
    localparam logic [1:0] CAUSE_NEWLINE = 2'd1;
    localparam logic [1:0] CAUSE_LIMIT   = 2'd2;
    localparam logic [1:0] CAUSE_NONE    = 2'd3;

    // special bytes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;

    // config reset values
    localparam logic [6:0] RST_MAX_TOKENS = 7'd20;
    localparam logic [2:0] RST_SEP_COUNT  = 3'd1;
    localparam logic [7:0] RST_SEP_A      = 8'd32;
    localparam logic [7:0] RST_SEP_B      = 8'd9;
    localparam logic [7:0] RST_SEP_C      = 8'd44;
    localparam logic [7:0] RST_SEP_D      = 8'd59;

    typedef struct packed {
        logic       inside_quotes;
        logic       backslash_held;
        logic       scan_stopped;
        logic       at_string_start;
        logic [1:0] held_cause;
    } t_flags;

    localparam t_flags FLAGS_RESET = '{
        inside_quotes:   1'b0,
        backslash_held:  1'b0,
        scan_stopped:    1'b0,
        at_string_start: 1'b1,
        held_cause:      CAUSE_END
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [5:0] token_index;
        logic [5:0] token_count;
        logic [1:0] stop_cause;
        logic       run_last;
    } t_result;

    function automatic t_result mk_result(
        input logic [1:0] kind,
        input logic [7:0] out_byte,
        input logic [5:0] token_index,
        input logic [5:0] token_count,
        input logic [1:0] stop_cause
    );
        t_result r;
        r.kind        = kind;
        r.out_byte    = out_byte;
        r.token_index = token_index;
        r.token_count = token_count;
        r.stop_cause  = stop_cause;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/qft_step.sv =====
// ----------------------------------------------------------------------------
// qft_step
// per-byte tokenizer logic: next string state and up to two results
// ----------------------------------------------------------------------------
module qft_step #(
    parameter int TW   = 6,
    parameter int NSEP = 4,
    parameter int TOKEN_LIMIT = 64
) (
    input  logic [7:0]          i_byte,
    input  qft_pkg::t_flags     i_flags,
    input  logic [TW-1:0]       i_token,
    input  logic [6:0]          i_max_tokens,
    input  logic [2:0]          i_sep_count,
    input  logic [7:0]          i_sep_char [NSEP],
    output qft_pkg::t_flags     o_flags,
    output logic [TW-1:0]       o_token,
    output logic [1:0]          o_nres,
    output qft_pkg::t_result    o_res0,
    output qft_pkg::t_result    o_res1
);

    localparam int CW = (TW + 2 > 9) ? TW + 2 : 9;

    logic            is_sep;
    logic            any_sep;
    logic            prefix_ok;
    logic            split_off;
    logic            stopped;
    logic [1:0]      cause;
    logic [1:0]      done_cause;
    logic [5:0]      tok6;
    logic [5:0]      count6;
    logic [CW-1:0]   tok2;
    logic            limit_hit;
    logic            handled;
    qft_pkg::t_result res [2];
    logic [1:0]      nres;

    always_comb begin
        prefix_ok = 1'b1;
        is_sep    = 1'b0;
        for (int i = 0; i < NSEP; i++) begin
            prefix_ok = prefix_ok && (i_sep_char[i] != 8'd0);
            if (prefix_ok && (i < int'(i_sep_count)) && (i_sep_char[i] == i_byte)) begin
                is_sep = 1'b1;
            end
        end
    end

    assign any_sep   = (i_sep_count != 3'd0) && (i_sep_char[0] != 8'd0);
    assign tok6      = 6'(i_token);
    assign count6    = 6'(i_token + 1'b1);
    assign tok2      = CW'(i_token) + CW'(2);
    assign limit_hit = (tok2 >= CW'(i_max_tokens)) || (tok2 >= CW'(TOKEN_LIMIT));
    assign split_off = i_flags.at_string_start &&
                       ((i_byte == qft_pkg::CH_NUL) || !any_sep || (i_max_tokens <= 7'd1));
    assign stopped   = i_flags.scan_stopped || split_off;
    assign cause     = split_off ? qft_pkg::CAUSE_NONE : i_flags.held_cause;

    always_comb begin
        o_flags    = i_flags;
        o_token    = i_token;
        res[0]     = '0;
        res[1]     = '0;
        nres       = 2'd0;
        handled    = 1'b0;
        done_cause = qft_pkg::CAUSE_END;
        o_flags.at_string_start = 1'b0;
        if (split_off) begin
            o_flags.scan_stopped = 1'b1;
            o_flags.held_cause   = qft_pkg::CAUSE_NONE;
        end
        if (i_byte == qft_pkg::CH_NUL) begin
            if (i_flags.backslash_held) begin
                res[nres[0]] = qft_pkg::mk_result(qft_pkg::KIND_BYTE, qft_pkg::CH_BSLASH,
                                                  tok6, 6'd0, qft_pkg::CAUSE_END);
                nres = nres + 2'd1;
            end
            done_cause = stopped ? cause : qft_pkg::CAUSE_END;
            res[nres[0]] = qft_pkg::mk_result(qft_pkg::KIND_DONE, 8'd0, 6'd0,
                               (done_cause == qft_pkg::CAUSE_NONE) ? 6'd0 : count6,
                               done_cause);
            nres    = nres + 2'd1;
            o_flags = qft_pkg::FLAGS_RESET;
            o_token = '0;
        end else if (!stopped) begin
            if (i_flags.backslash_held) begin
                o_flags.backslash_held = 1'b0;
                res[nres[0]] = qft_pkg::mk_result(qft_pkg::KIND_BYTE, qft_pkg::CH_BSLASH,
                                                  tok6, 6'd0, qft_pkg::CAUSE_END);
                nres = nres + 2'd1;
                if (i_byte == qft_pkg::CH_QUOTE) begin
                    res[nres[0]] = qft_pkg::mk_result(qft_pkg::KIND_BYTE, qft_pkg::CH_QUOTE,
                                                      tok6, 6'd0, qft_pkg::CAUSE_END);
                    nres    = nres + 2'd1;
                    handled = 1'b1;
                end
            end
            if (!handled) begin
                if (!i_flags.inside_quotes && (i_byte == qft_pkg::CH_NEWLINE)) begin
                    o_flags.scan_stopped = 1'b1;
                    o_flags.held_cause   = qft_pkg::CAUSE_NEWLINE;
                end else if (!i_flags.inside_quotes && is_sep) begin
                    if (limit_hit) begin
                        o_flags.scan_stopped = 1'b1;
                        o_flags.held_cause   = qft_pkg::CAUSE_LIMIT;
                    end else begin
                        res[nres[0]] = qft_pkg::mk_result(qft_pkg::KIND_CLOSE, 8'd0,
                                                          tok6, 6'd0, qft_pkg::CAUSE_END);
                        nres    = nres + 2'd1;
                        o_token = i_token + 1'b1;
                    end
                end else if (i_byte == qft_pkg::CH_QUOTE) begin
                    o_flags.inside_quotes = !i_flags.inside_quotes;
                    res[nres[0]] = qft_pkg::mk_result(qft_pkg::KIND_BYTE, i_byte,
                                                      tok6, 6'd0, qft_pkg::CAUSE_END);
                    nres = nres + 2'd1;
                end else if (i_flags.inside_quotes && (i_byte == qft_pkg::CH_BSLASH)) begin
                    o_flags.backslash_held = 1'b1;
                end else begin
                    res[nres[0]] = qft_pkg::mk_result(qft_pkg::KIND_BYTE, i_byte,
                                                      tok6, 6'd0, qft_pkg::CAUSE_END);
                    nres = nres + 2'd1;
                end
            end
        end
        if (nres == 2'd1) begin
            res[0].run_last = 1'b1;
        end else if (nres == 2'd2) begin
            res[1].run_last = 1'b1;
        end
    end

    assign o_nres = nres;
    assign o_res0 = res[0];
    assign o_res1 = res[1];

endmodule

// ===== rtl/quoted_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// quoted_field_tokenizer
// quote-aware separator tokenizer, one string byte per input word
// ----------------------------------------------------------------------------
// path: input register, then result queue, which drives the outputs
// throughput: one byte per cycle while the output is ready; a byte giving two
//   results holds the input while the two-entry result queue drains
// reset: synchronous active-low i_rst_n clears string state, queue and config
//   registers to their defaults; no clearing pass
// ----------------------------------------------------------------------------
`include "quoted_field_tokenizer_macros.svh"

module quoted_field_tokenizer #(
    parameter int TOKEN_LIMIT = 64,
    parameter int SEP_SLOTS   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [5:0]  o_token_index,
    output logic [5:0]  o_token_count,
    output logic [1:0]  o_stop_cause,
    output logic        o_run_last,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TW   = (TOKEN_LIMIT > 2) ? $clog2(TOKEN_LIMIT) : 1;
    localparam int NSEP = (SEP_SLOTS < qft_pkg::SEP_REGS) ? SEP_SLOTS : qft_pkg::SEP_REGS;

    logic [6:0]        r_max_tokens;
    logic [2:0]        r_sep_count;
    logic [7:0]        r_sep_char [NSEP];
    logic [7:0]        sep_view   [qft_pkg::SEP_REGS];
    logic [2:0]        reg_idx;
    logic              cfg_wr;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    qft_pkg::t_flags   r_flags;
    qft_pkg::t_flags   n_flags;
    logic [TW-1:0]     r_token;
    logic [TW-1:0]     n_token;
    logic [1:0]        s_nres;
    qft_pkg::t_result  s_res0;
    qft_pkg::t_result  s_res1;

    qft_pkg::t_result  r_q0;
    qft_pkg::t_result  r_q1;
    logic [1:0]        r_cnt;
    logic              pop;
    logic              can_push;
    logic              push;

    // config registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tokens <= qft_pkg::RST_MAX_TOKENS;
            r_sep_count  <= qft_pkg::RST_SEP_COUNT;
            r_sep_char[0] <= qft_pkg::RST_SEP_A;
            if (NSEP > 1) r_sep_char[1 % NSEP] <= qft_pkg::RST_SEP_B;
            if (NSEP > 2) r_sep_char[2 % NSEP] <= qft_pkg::RST_SEP_C;
            if (NSEP > 3) r_sep_char[3 % NSEP] <= qft_pkg::RST_SEP_D;
        end else if (cfg_wr) begin
            if (reg_idx == qft_pkg::REG_MAX_TOKENS) r_max_tokens <= pwdata[6:0];
            if (reg_idx == qft_pkg::REG_SEP_COUNT)  r_sep_count  <= pwdata[2:0];
            for (int i = 0; i < NSEP; i++) begin
                if (reg_idx == qft_pkg::REG_SEP_A + 3'(i)) r_sep_char[i] <= pwdata[7:0];
            end
        end
    end

    for (genvar g = 0; g < qft_pkg::SEP_REGS; g++) begin : g_sep_view
        if (g < NSEP) begin : g_on
            assign sep_view[g] = r_sep_char[g];
        end else begin : g_off
            assign sep_view[g] = 8'd0;
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (reg_idx)
            qft_pkg::REG_MAX_TOKENS: prdata = {25'd0, r_max_tokens};
            qft_pkg::REG_SEP_COUNT:  prdata = {29'd0, r_sep_count};
            qft_pkg::REG_SEP_A:      prdata = {24'd0, sep_view[0]};
            qft_pkg::REG_SEP_B:      prdata = {24'd0, sep_view[1]};
            qft_pkg::REG_SEP_C:      prdata = {24'd0, sep_view[2]};
            qft_pkg::REG_SEP_D:      prdata = {24'd0, sep_view[3]};
            default:                 prdata = 32'd0;
        endcase
    end

    // input register and step logic
    assign pop      = o_out_valid && i_out_ready;
    assign can_push = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign push     = r_in_valid && can_push;
    assign o_in_ready = !r_in_valid || can_push;

    qft_step #(
        .TW          (TW),
        .NSEP        (NSEP),
        .TOKEN_LIMIT (TOKEN_LIMIT)
    ) u_step (
        .i_byte       (r_in_byte),
        .i_flags      (r_flags),
        .i_token      (r_token),
        .i_max_tokens (r_max_tokens),
        .i_sep_count  (r_sep_count),
        .i_sep_char   (r_sep_char),
        .o_flags      (n_flags),
        .o_token      (n_token),
        .o_nres       (s_nres),
        .o_res0       (s_res0),
        .o_res1       (s_res1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_flags    <= qft_pkg::FLAGS_RESET;
            r_token    <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (push) begin
                r_in_valid <= 1'b0;
            end
            if (push) begin
                r_flags <= n_flags;
                r_token <= n_token;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    // two-entry result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (push) begin
            r_cnt <= s_nres;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q0 <= s_res0;
            r_q1 <= s_res1;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    assign o_out_valid   = (r_cnt != 2'd0);
    assign o_kind        = r_q0.kind;
    assign o_out_byte    = r_q0.out_byte;
    assign o_token_index = r_q0.token_index;
    assign o_token_count = r_q0.token_count;
    assign o_stop_cause  = r_q0.stop_cause;
    assign o_run_last    = r_q0.run_last;

    `QFT_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2)
    `QFT_ASSERT_IMP(a_push_room, i_clk, i_rst_n, push,
        (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop))
    `QFT_ASSERT_IMP(a_pair_held, i_clk, i_rst_n, o_out_valid && !o_run_last, r_cnt == 2'd2)
    `QFT_ASSERT_NXT(a_done_clears, i_clk, i_rst_n,
        push && (s_nres != 2'd0) && ((s_res0.kind == qft_pkg::KIND_DONE) ||
        (s_res1.kind == qft_pkg::KIND_DONE)), r_flags.at_string_start && (r_token == '0))

endmodule
